/* design/vps_pkg.sv */
// Shared package of the Verlet point-and-stick step block.
// Holds the word types, register codes, reset values and saturation helper.
// No dependencies; every other file of the block uses it.
package vps_pkg;

    localparam int unsigned DATA_W          = 32;
    localparam int unsigned UDATA_W         = 31;
    localparam int unsigned FRAC_BITS_DEF   = 16;
    localparam int unsigned STAGE_STEPS_DEF = 4;
    localparam int unsigned RAD_W           = 64;
    localparam int unsigned ROOT_W          = 32;
    localparam int unsigned NUM_W           = 63;
    localparam int unsigned DEN_W           = 33;
    localparam int unsigned QUO_W           = 32;
    localparam int unsigned CFG_IDX_W       = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIME_STEP    = 3'd0,
        REG_GRAVITY_X    = 3'd1,
        REG_GRAVITY_Y    = 3'd2,
        REG_AREA_WIDTH   = 3'd3,
        REG_AREA_HEIGHT  = 3'd4,
        REG_POINT_RADIUS = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        ACT_INTEGRATE = 1'b0,
        ACT_STICK     = 1'b1
    } action_t;

    localparam logic [UDATA_W-1:0]       RST_TIME_STEP    = 31'd65536;
    localparam logic signed [DATA_W-1:0] RST_GRAVITY_X    = 32'sd0;
    localparam logic signed [DATA_W-1:0] RST_GRAVITY_Y    = 32'sd655360;
    localparam logic [UDATA_W-1:0]       RST_AREA_WIDTH   = 31'd41943040;
    localparam logic [UDATA_W-1:0]       RST_AREA_HEIGHT  = 31'd31457280;
    localparam logic [UDATA_W-1:0]       RST_POINT_RADIUS = 31'd327680;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        action_t                    action;
        logic signed [DATA_W-1:0]   a_pos_x;
        logic signed [DATA_W-1:0]   a_pos_y;
        logic signed [DATA_W-1:0]   a_prev_x;
        logic signed [DATA_W-1:0]   a_prev_y;
        logic                       a_movable;
        logic signed [DATA_W-1:0]   b_pos_x;
        logic signed [DATA_W-1:0]   b_pos_y;
        logic                       b_movable;
        logic [UDATA_W-1:0]         stick_length;
    } req_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_a_x;
        logic signed [DATA_W-1:0] new_a_y;
        logic signed [DATA_W-1:0] new_a_prev_x;
        logic signed [DATA_W-1:0] new_a_prev_y;
        logic signed [DATA_W-1:0] new_b_x;
        logic signed [DATA_W-1:0] new_b_y;
    } rsp_word_t;

    // Saturates a wide signed value to the 32-bit two's complement range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX)
            r = 32'sh7FFF_FFFF;
        else if (v < SAT_MIN)
            r = 32'sh8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

/* design/vps_intf.sv */
// Channel interfaces of the Verlet point-and-stick step block.
// Depends on vps_pkg for the word types and widths.
interface vps_req_if;
    logic                valid;
    logic                ready;
    vps_pkg::req_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vps_rsp_if;
    logic                valid;
    logic                ready;
    vps_pkg::rsp_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vps_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [vps_pkg::CFG_IDX_W-1:0]      index;
    logic [vps_pkg::DATA_W-1:0]         data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/vps_isqrt.sv */
// Pipelined integer square root, floor(sqrt(radicand)), STEPS result bits per stage.
// Depends on vps_pkg for the widths.
module vps_isqrt #(
    parameter int unsigned STEPS = vps_pkg::STAGE_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [vps_pkg::RAD_W-1:0]   radicand,
    output logic [vps_pkg::ROOT_W-1:0]  root
);

    localparam int unsigned RAD_W  = vps_pkg::RAD_W;
    localparam int unsigned ROOT_W = vps_pkg::ROOT_W;
    localparam int unsigned REM_W  = ROOT_W + 4;
    localparam int unsigned NST    = (ROOT_W + STEPS - 1) / STEPS;

    logic [REM_W-1:0]  rem_reg  [NST];
    logic [ROOT_W-1:0] root_reg [NST];
    logic [RAD_W-1:0]  rad_reg  [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        // One result bit per step: bring down two radicand bits and try 4*root+1.
        always_comb begin
            logic [REM_W-1:0] rem_t;
            logic [REM_W-1:0] trial;
            rem_t     = '0;
            trial     = '0;
            rem_next  = rem_in;
            root_next = root_in;
            rad_next  = rad_in;
            for (int j = 0; j < STEPS; j++) begin
                if (k * STEPS + j < ROOT_W) begin
                    rem_t    = {rem_next[REM_W-3:0], rad_next[RAD_W-1 -: 2]};
                    trial    = REM_W'({root_next, 2'b01});
                    rad_next = rad_next << 2;
                    if (rem_t >= trial) begin
                        rem_next  = rem_t - trial;
                        root_next = {root_next[ROOT_W-2:0], 1'b1};
                    end else begin
                        rem_next  = rem_t;
                        root_next = {root_next[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk) begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
            end
        end
    end

    assign root = root_reg[NST-1];

endmodule

/* design/vps_div.sv */
// Pipelined restoring divider for unsigned magnitudes, STEPS quotient bits per stage.
// Depends on vps_pkg for the widths; the quotient must fit in QUO_W bits.
module vps_div #(
    parameter int unsigned STEPS = vps_pkg::STAGE_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [vps_pkg::NUM_W-1:0]   num,
    input  logic [vps_pkg::DEN_W-1:0]   den,
    output logic [vps_pkg::QUO_W-1:0]   quo
);

    localparam int unsigned NUM_W = vps_pkg::NUM_W;
    localparam int unsigned DEN_W = vps_pkg::DEN_W;
    localparam int unsigned QUO_W = vps_pkg::QUO_W;
    localparam int unsigned REM_W = DEN_W + 2;
    localparam int unsigned NST   = (QUO_W + STEPS - 1) / STEPS;

    logic [REM_W-1:0] rem_reg [NST];
    logic [QUO_W-1:0] low_reg [NST];
    logic [QUO_W-1:0] quo_reg [NST];
    logic [DEN_W-1:0] den_reg [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [QUO_W-1:0] low_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W-1:0] den_in;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] low_next;
        logic [QUO_W-1:0] quo_next;

        if (k == 0) begin : g_first
            // The upper numerator bits are already below the divisor.
            assign rem_in = REM_W'(num[NUM_W-1:QUO_W]);
            assign low_in = num[QUO_W-1:0];
            assign quo_in = '0;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb begin
            logic [REM_W-1:0] rem_t;
            rem_t    = '0;
            rem_next = rem_in;
            low_next = low_in;
            quo_next = quo_in;
            for (int j = 0; j < STEPS; j++) begin
                if (k * STEPS + j < QUO_W) begin
                    rem_t    = {rem_next[REM_W-2:0], low_next[QUO_W-1]};
                    low_next = low_next << 1;
                    if (rem_t >= REM_W'(den_in)) begin
                        rem_next = rem_t - REM_W'(den_in);
                        quo_next = {quo_next[QUO_W-2:0], 1'b1};
                    end else begin
                        rem_next = rem_t;
                        quo_next = {quo_next[QUO_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk) begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                low_reg[k] <= low_next;
                quo_reg[k] <= quo_next;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[NST-1];

endmodule

/* design/verlet_point_and_stick_step.sv */
// Top level of the Verlet point-and-stick step block.
// Depends on vps_pkg, vps_intf (channels), vps_isqrt and vps_div.
//
// This block takes one word per clock cycle on req and returns exactly one
// result word per request on rsp, in order. A request either integrates one
// Verlet point (velocity and half-gravity terms, then wall clamping) or
// relaxes one stick between two points toward its rest length. All values are
// signed fixed point with FRAC_BITS fraction bits and every result saturates
// to 32 bits. The datapath is a single pipeline: three front stages (differences,
// multiplies, sums), the square root pipeline, the divider pipeline and the
// output register. Throughput is one word per cycle; the whole pipeline holds
// only when the output register is full and not taken. Configuration writes
// are accepted at any time on cfg and must only be issued while no request is
// in flight.
module verlet_point_and_stick_step #(
    parameter int unsigned FRAC_BITS   = vps_pkg::FRAC_BITS_DEF,
    parameter int unsigned STAGE_STEPS = vps_pkg::STAGE_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    vps_cfg_if.sink     cfg,
    vps_req_if.sink     req,
    vps_rsp_if.source   rsp
);

    localparam int unsigned DATA_W  = vps_pkg::DATA_W;
    localparam int unsigned UDATA_W = vps_pkg::UDATA_W;
    localparam int unsigned NUM_W   = vps_pkg::NUM_W;
    localparam int unsigned DEN_W   = vps_pkg::DEN_W;
    localparam int unsigned ROOT_W  = vps_pkg::ROOT_W;
    localparam int unsigned QUO_W   = vps_pkg::QUO_W;
    localparam int unsigned NSQ     = (ROOT_W + STAGE_STEPS - 1) / STAGE_STEPS;
    localparam int unsigned NDV     = (QUO_W + STAGE_STEPS - 1) / STAGE_STEPS;
    localparam int unsigned DLY     = NSQ + NDV;

    // Fields that ride along the whole pipeline.
    typedef struct packed {
        vps_pkg::action_t           act;
        logic                       amov;
        logic                       bmov;
        logic signed [DATA_W-1:0]   ax;
        logic signed [DATA_W-1:0]   ay;
        logic signed [DATA_W-1:0]   px;
        logic signed [DATA_W-1:0]   py;
        logic signed [DATA_W-1:0]   bx;
        logic signed [DATA_W-1:0]   by;
        logic signed [DATA_W-1:0]   cx;
        logic signed [DATA_W-1:0]   cy;
        logic                       sx;
        logic                       sy;
    } pass_t;

    typedef struct packed {
        pass_t                      p;
        logic signed [DATA_W-1:0]   vx;
        logic signed [DATA_W-1:0]   vy;
        logic [DATA_W-1:0]          adx;
        logic [DATA_W-1:0]          ady;
        logic [UDATA_W-1:0]         len;
    } stage_a_t;

    typedef struct packed {
        pass_t                      p;
        logic signed [63:0]         pvx;
        logic signed [63:0]         pvy;
        logic signed [63:0]         pgx;
        logic signed [63:0]         pgy;
        logic [63:0]                sqx;
        logic [63:0]                sqy;
        logic [NUM_W-1:0]           nmx;
        logic [NUM_W-1:0]           nmy;
    } stage_b_t;

    typedef struct packed {
        pass_t                      p;
        logic signed [DATA_W-1:0]   nx;
        logic signed [DATA_W-1:0]   ny;
        logic [NUM_W-1:0]           nmx;
        logic [NUM_W-1:0]           nmy;
    } side_t;

    // Configuration registers.
    logic [UDATA_W-1:0]       time_step_reg;
    logic signed [DATA_W-1:0] gravity_x_reg;
    logic signed [DATA_W-1:0] gravity_y_reg;
    logic [UDATA_W-1:0]       area_width_reg;
    logic [UDATA_W-1:0]       area_height_reg;
    logic [UDATA_W-1:0]       point_radius_reg;

    // dt*dt/2 in fixed point, registered from the time step.
    logic [UDATA_W-1:0]       hdt2_reg;
    logic [UDATA_W-1:0]       hdt2_next;
    logic [61:0]              dt_sq;
    logic [61:0]              dt_sq_half;

    logic                     en;

    logic                     a_v_reg;
    stage_a_t                 a_reg;
    stage_a_t                 a_next;
    logic                     b_v_reg;
    stage_b_t                 b_reg;
    stage_b_t                 b_next;
    logic                     c_v_reg;
    side_t                    c_reg;
    side_t                    c_next;
    logic [63:0]              s_reg;
    logic [63:0]              s_next;

    logic                     side_v_reg [DLY];
    side_t                    side_reg   [DLY];

    logic [ROOT_W-1:0]        root;
    logic [DEN_W-1:0]         den;
    logic [QUO_W-1:0]         quo_x;
    logic [QUO_W-1:0]         quo_y;

    logic                     rsp_valid_reg;
    vps_pkg::rsp_word_t       rsp_data_reg;
    vps_pkg::rsp_word_t       rsp_data_next;
    vps_pkg::action_t         rsp_act_reg;

    logic signed [32:0]       dxf;
    logic signed [32:0]       dyf;
    logic signed [32:0]       sumx;
    logic signed [32:0]       sumy;
    logic                     wide_d;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [DATA_W-1:0] dt_s;
    logic signed [DATA_W-1:0] hdt_s;

    // Wall clamp of one axis: returns {new position, new previous position}.
    function automatic logic [63:0] clamp_axis(
        input logic signed [DATA_W-1:0] pos,
        input logic signed [DATA_W-1:0] old,
        input logic [UDATA_W-1:0]       size,
        input logic [UDATA_W-1:0]       radius
    );
        logic signed [33:0]       lo;
        logic signed [33:0]       hi;
        logic signed [33:0]       p;
        logic signed [33:0]       o;
        logic signed [DATA_W-1:0] npos;
        logic signed [DATA_W-1:0] nprev;
        lo = signed'({3'b000, radius});
        hi = signed'({3'b000, size}) - lo;
        p  = 34'(pos);
        o  = 34'(old);
        // The low wall is tested first, so it wins when the area is too small.
        if (p <= lo) begin
            npos  = lo[DATA_W-1:0];
            nprev = vps_pkg::sat32(64'(lo + p - o));
        end else if (p >= hi) begin
            npos  = hi[DATA_W-1:0];
            nprev = vps_pkg::sat32(64'(hi + p - o));
        end else begin
            npos  = pos;
            nprev = old;
        end
        return {npos, nprev};
    endfunction

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken; unknown indexes are
    // dropped.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            time_step_reg    <= vps_pkg::RST_TIME_STEP;
            gravity_x_reg    <= vps_pkg::RST_GRAVITY_X;
            gravity_y_reg    <= vps_pkg::RST_GRAVITY_Y;
            area_width_reg   <= vps_pkg::RST_AREA_WIDTH;
            area_height_reg  <= vps_pkg::RST_AREA_HEIGHT;
            point_radius_reg <= vps_pkg::RST_POINT_RADIUS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                vps_pkg::REG_TIME_STEP:    time_step_reg    <= cfg.data[UDATA_W-1:0];
                vps_pkg::REG_GRAVITY_X:    gravity_x_reg    <= signed'(cfg.data);
                vps_pkg::REG_GRAVITY_Y:    gravity_y_reg    <= signed'(cfg.data);
                vps_pkg::REG_AREA_WIDTH:   area_width_reg   <= cfg.data[UDATA_W-1:0];
                vps_pkg::REG_AREA_HEIGHT:  area_height_reg  <= cfg.data[UDATA_W-1:0];
                vps_pkg::REG_POINT_RADIUS: point_radius_reg <= cfg.data[UDATA_W-1:0];
                default: ;
            endcase
        end
    end

    // The gravity term needs dt*dt/2, saturated to the register range. It
    // only follows the time step, so it is kept in a register of its own.
    assign dt_sq      = time_step_reg * time_step_reg;
    assign dt_sq_half = dt_sq >> (FRAC_BITS + 1);
    assign hdt2_next  = (dt_sq_half > 62'h7FFF_FFFF) ? '1 : dt_sq_half[UDATA_W-1:0];

    always_ff @(posedge clk) begin
        hdt2_reg <= hdt2_next;
    end

    // ------------------------------------------------------------------
    // Flow control. Every stage moves together; the pipeline holds only
    // when the output register is full and the sink does not take it.
    // ------------------------------------------------------------------
    assign en        = !rsp_valid_reg || rsp.ready;
    assign req.ready = en;

    // ------------------------------------------------------------------
    // Stage A: velocity, stick direction and center.
    // ------------------------------------------------------------------
    assign dxf  = 33'(req.data.a_pos_x) - 33'(req.data.b_pos_x);
    assign dyf  = 33'(req.data.a_pos_y) - 33'(req.data.b_pos_y);
    assign sumx = 33'(req.data.a_pos_x) + 33'(req.data.b_pos_x);
    assign sumy = 33'(req.data.a_pos_y) + 33'(req.data.b_pos_y);

    // When either difference reaches 2^31 in magnitude both are halved, so
    // the squares and their sum stay within 64 bits.
    assign wide_d = (dxf[32] != dxf[31]) || (dxf[32:31] == 2'b11 && dxf[30:0] == '0)
                 || (dyf[32] != dyf[31]) || (dyf[32:31] == 2'b11 && dyf[30:0] == '0);
    assign dx = wide_d ? dxf[32:1] : dxf[DATA_W-1:0];
    assign dy = wide_d ? dyf[32:1] : dyf[DATA_W-1:0];

    always_comb begin
        a_next.p.act  = req.data.action;
        a_next.p.amov = req.data.a_movable;
        a_next.p.bmov = req.data.b_movable;
        a_next.p.ax   = req.data.a_pos_x;
        a_next.p.ay   = req.data.a_pos_y;
        a_next.p.px   = req.data.a_prev_x;
        a_next.p.py   = req.data.a_prev_y;
        a_next.p.bx   = req.data.b_pos_x;
        a_next.p.by   = req.data.b_pos_y;
        a_next.p.cx   = sumx[32:1];
        a_next.p.cy   = sumy[32:1];
        a_next.p.sx   = dx[DATA_W-1];
        a_next.p.sy   = dy[DATA_W-1];
        a_next.vx     = vps_pkg::sat32(64'(req.data.a_pos_x) - 64'(req.data.a_prev_x));
        a_next.vy     = vps_pkg::sat32(64'(req.data.a_pos_y) - 64'(req.data.a_prev_y));
        a_next.adx    = dx[DATA_W-1] ? (~dx + 32'd1) : dx;
        a_next.ady    = dy[DATA_W-1] ? (~dy + 32'd1) : dy;
        a_next.len    = req.data.stick_length;
    end

    // ------------------------------------------------------------------
    // Stage B: all products, each one 32 by 32 bits at most.
    // ------------------------------------------------------------------
    assign dt_s  = signed'({1'b0, time_step_reg});
    assign hdt_s = signed'({1'b0, hdt2_reg});

    always_comb begin
        b_next.p   = a_reg.p;
        b_next.pvx = a_reg.vx * dt_s;
        b_next.pvy = a_reg.vy * dt_s;
        b_next.pgx = gravity_x_reg * hdt_s;
        b_next.pgy = gravity_y_reg * hdt_s;
        b_next.sqx = a_reg.adx * a_reg.adx;
        b_next.sqy = a_reg.ady * a_reg.ady;
        b_next.nmx = a_reg.adx * a_reg.len;
        b_next.nmy = a_reg.ady * a_reg.len;
    end

    // ------------------------------------------------------------------
    // Stage C: integrated position (floor shifts) and the squared length.
    // ------------------------------------------------------------------
    always_comb begin
        c_next.p   = b_reg.p;
        c_next.nx  = vps_pkg::sat32(64'(b_reg.p.ax) + (b_reg.pvx >>> FRAC_BITS)
                                    + (b_reg.pgx >>> FRAC_BITS));
        c_next.ny  = vps_pkg::sat32(64'(b_reg.p.ay) + (b_reg.pvy >>> FRAC_BITS)
                                    + (b_reg.pgy >>> FRAC_BITS));
        c_next.nmx = b_reg.nmx;
        c_next.nmy = b_reg.nmy;
        s_next     = b_reg.sqx + b_reg.sqy;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= req.valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root and division pipelines. The side line delays everything
    // else so that it lines up with the root and then with the quotients.
    // ------------------------------------------------------------------
    vps_isqrt #(
        .STEPS (STAGE_STEPS)
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (s_reg),
        .root     (root)
    );

    // The length is zero only for a zero direction, whose numerators are
    // zero as well; dividing by one then gives the required zero change.
    assign den = (root == '0) ? DEN_W'(1) : {root, 1'b0};

    vps_div #(
        .STEPS (STAGE_STEPS)
    ) u_div_x (
        .clk (clk),
        .en  (en),
        .num (side_reg[NSQ-1].nmx),
        .den (den),
        .quo (quo_x)
    );

    vps_div #(
        .STEPS (STAGE_STEPS)
    ) u_div_y (
        .clk (clk),
        .en  (en),
        .num (side_reg[NSQ-1].nmy),
        .den (den),
        .quo (quo_y)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < DLY; i++)
                side_v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            side_v_reg[0] <= c_v_reg;
            for (int i = 1; i < DLY; i++)
                side_v_reg[i] <= side_v_reg[i-1];
        end
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            side_reg[0] <= c_reg;
            for (int i = 1; i < DLY; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // ------------------------------------------------------------------
    // Final stage: wall clamping for integrate, signed change and endpoint
    // update for stick, then the output register.
    // ------------------------------------------------------------------
    always_comb begin
        logic [63:0]        cl_x;
        logic [63:0]        cl_y;
        logic signed [33:0] chx;
        logic signed [33:0] chy;
        side_t              sd;
        sd   = side_reg[DLY-1];
        cl_x = clamp_axis(sd.nx, sd.p.ax, area_width_reg, point_radius_reg);
        cl_y = clamp_axis(sd.ny, sd.p.ay, area_height_reg, point_radius_reg);
        chx  = sd.p.sx ? -signed'(34'(quo_x)) : signed'(34'(quo_x));
        chy  = sd.p.sy ? -signed'(34'(quo_y)) : signed'(34'(quo_y));
        if (sd.p.act == vps_pkg::ACT_INTEGRATE) begin
            if (sd.p.amov) begin
                rsp_data_next.new_a_x      = cl_x[63:32];
                rsp_data_next.new_a_y      = cl_y[63:32];
                rsp_data_next.new_a_prev_x = cl_x[31:0];
                rsp_data_next.new_a_prev_y = cl_y[31:0];
            end else begin
                rsp_data_next.new_a_x      = sd.p.ax;
                rsp_data_next.new_a_y      = sd.p.ay;
                rsp_data_next.new_a_prev_x = sd.p.px;
                rsp_data_next.new_a_prev_y = sd.p.py;
            end
            rsp_data_next.new_b_x = '0;
            rsp_data_next.new_b_y = '0;
        end else begin
            rsp_data_next.new_a_x      = sd.p.amov ?
                vps_pkg::sat32(64'(sd.p.cx) + 64'(chx)) : sd.p.ax;
            rsp_data_next.new_a_y      = sd.p.amov ?
                vps_pkg::sat32(64'(sd.p.cy) + 64'(chy)) : sd.p.ay;
            rsp_data_next.new_a_prev_x = sd.p.px;
            rsp_data_next.new_a_prev_y = sd.p.py;
            rsp_data_next.new_b_x      = sd.p.bmov ?
                vps_pkg::sat32(64'(sd.p.cx) - 64'(chx)) : sd.p.bx;
            rsp_data_next.new_b_y      = sd.p.bmov ?
                vps_pkg::sat32(64'(sd.p.cy) - 64'(chy)) : sd.p.by;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rsp_valid_reg <= side_v_reg[DLY-1];
        end
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            rsp_data_reg <= rsp_data_next;
            rsp_act_reg  <= side_reg[DLY-1].p.act;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_front_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (a_v_reg && en) |=> b_v_reg)
        else $error("stage A word did not move into stage B");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(a_v_reg) && $stable(b_v_reg) && $stable(c_v_reg)
                 && $stable(side_v_reg[DLY-1])))
        else $error("pipeline valid bits changed during a stall");

    a_tail_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (side_v_reg[DLY-1] && en) |=> rsp_valid_reg)
        else $error("finished word did not reach the output register");

    a_integrate_b_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_act_reg == vps_pkg::ACT_INTEGRATE)
            |-> (rsp_data_reg.new_b_x == '0 && rsp_data_reg.new_b_y == '0))
        else $error("integrate result carries a nonzero point b");

endmodule
